// File: design/hsv2rgb_pkg.sv
// shared types, widths and helpers for the hsv to rgb converter
// no dependencies; used by the top level, the channel scaler and the checker
package hsv2rgb_pkg;

  localparam int FRAC_BITS  = 12;                 // fraction bits of saturation and value
  localparam int UNIT_W     = FRAC_BITS + 1;      // clamped 0..1 inclusive
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int PROD_W     = 2 * FRAC_BITS + 1;  // chroma and offset, 0..2^(2F)
  localparam int NUM_W      = 2 * FRAC_BITS + 6;  // channel numerator, below 64*2^(2F)
  localparam int SCALED_W   = NUM_W + 5;          // numerator times 17
  localparam int OUT_LSB    = 2 * FRAC_BITS + 2;  // 255/60 = 17/4, so shift by 2F+2

  localparam int HUE_W      = 16;
  localparam int HUE_RECIP  = 46604;              // ceil(2^24 / 360), exact for 16-bit hue
  localparam int HUE_SHIFT  = 24;
  localparam int QUOT_W     = 8;                  // hue / 360 is at most 182
  localparam int DEG_W      = 9;
  localparam int DEG_FULL   = 360;
  localparam int DEG_SECTOR = 60;
  localparam int TRI_W      = 6;                  // triangle weight 0..60

  localparam int PIPE_DEPTH = 5;                  // depth of the pipeline, from accept edge to result strobe

  typedef struct packed {
    logic [15:0]        hue;
    logic signed [15:0] saturation;
    logic signed [15:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // clamp a signed fixed-point fraction to 0..1
  function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [15:0] raw);
    logic [16:0] mag;
    mag = {2'b00, raw[14:0]};
    if (raw[15]) begin
      return '0;
    end else if (mag > 17'(ONE)) begin
      return UNIT_W'(ONE);
    end else begin
      return UNIT_W'(mag);
    end
  endfunction

endpackage

// File: design/hsv2rgb_scale.sv
// one colour channel: adds the offset numerator and scales by 255/60 with truncation
// depends on hsv2rgb_pkg
module hsv2rgb_scale (
  input  logic [hsv2rgb_pkg::NUM_W-1:0] base,
  input  logic [hsv2rgb_pkg::NUM_W-1:0] offset,
  output logic [7:0]                    level
);
  import hsv2rgb_pkg::*;

  logic [NUM_W-1:0]    sum;
  logic [SCALED_W-1:0] scaled;

  // sum never exceeds 60 * 2^(2F), so no carry out
  assign sum    = base + offset;
  // 255 / (60 * 2^2F) = 17 / 2^(2F+2)
  assign scaled = (SCALED_W'(sum) << 4) + SCALED_W'(sum);
  assign level  = scaled[OUT_LSB+7:OUT_LSB];

endmodule

// File: design/hsv_to_rgb_converter.sv
// hsv to rgb converter top level: five-stage pipeline, one item per cycle
// depends on hsv2rgb_pkg and hsv2rgb_scale
//
//  channel   signals             direction  transfer
//  --------  ------------------  ---------  ------------------------------------
//  input     start, busy, hsv    in         taken at an edge with start high, busy low
//  result    done, rgb           out        shown for one cycle, marked by done
//
// an item can be taken in every cycle; busy is never raised
// each result passes through one register stage per step: hue reciprocal
//   multiply, chroma multiply, sector pick, numerator
//   multiplies, channel scale
// rst (synchronous) clears only the valid bits; items in flight are dropped
// the receiver cannot stall, so the pipeline never holds
module hsv_to_rgb_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hsv2rgb_pkg::hsv_t hsv,
  output logic              busy,
  output logic              done,
  output hsv2rgb_pkg::rgb_t rgb
);
  import hsv2rgb_pkg::*;

  typedef enum logic [2:0] {
    SEC_RY,  // red to yellow
    SEC_YG,  // yellow to green
    SEC_GC,  // green to cyan
    SEC_CB,  // cyan to blue
    SEC_BM,  // blue to magenta
    SEC_MR   // magenta to red
  } sector_t;

  // valid bits, one per stage
  logic v1, v2, v3, v4;

  // stage 1: clamped fractions and hue quotient
  logic [HUE_W-1:0]  hue1;
  logic [QUOT_W-1:0] quot1;
  logic [UNIT_W-1:0] sat1, val1;

  // stage 2: reduced hue, chroma, scaled value
  logic [DEG_W-1:0]  deg2;
  logic [PROD_W-1:0] chroma2, vfull2;

  // stage 3: sector, triangle weight, chroma and offset
  sector_t           sector3;
  logic [TRI_W-1:0]  tri3;
  logic [PROD_W-1:0] chroma3, offs3;

  // stage 4: numerators over 60 * 2^(2F)
  sector_t           sector4;
  logic [NUM_W-1:0]  xn4, cn4, mn4;

  // combinational signals
  logic [31:0]       hue_prod;
  logic [16:0]       deg_full;
  sector_t           sector;
  logic [DEG_W-1:0]  deg_base;
  logic              falling;
  logic [DEG_W-1:0]  deg_off;
  logic [TRI_W-1:0]  tri_w;
  logic [NUM_W-1:0]  base_r, base_g, base_b;
  logic [7:0]        lvl_r, lvl_g, lvl_b;

  // the pipeline never pushes back
  assign busy = 1'b0;

  // hue / 360 by reciprocal: the error stays below 1/360 of a unit, so it never
  // crosses an integer for a 16-bit hue
  assign hue_prod = 32'(hsv.hue) * 32'(HUE_RECIP);

  // hue mod 360 from the stored quotient
  assign deg_full = 17'(hue1) - (17'(quot1) * 17'(DEG_FULL));

  // sector pick: borders belong to the higher sector
  always_comb begin
    if (deg2 < DEG_W'(60)) begin
      sector = SEC_RY;
    end else if (deg2 < DEG_W'(120)) begin
      sector = SEC_YG;
    end else if (deg2 < DEG_W'(180)) begin
      sector = SEC_GC;
    end else if (deg2 < DEG_W'(240)) begin
      sector = SEC_CB;
    end else if (deg2 < DEG_W'(300)) begin
      sector = SEC_BM;
    end else begin
      sector = SEC_MR;
    end
  end

  // triangle weight 60 - |(h mod 120) - 60|: rising in even sectors, falling in odd
  always_comb begin
    case (sector)
      SEC_RY:  begin deg_base = DEG_W'(0);   falling = 1'b0; end
      SEC_YG:  begin deg_base = DEG_W'(60);  falling = 1'b1; end
      SEC_GC:  begin deg_base = DEG_W'(120); falling = 1'b0; end
      SEC_CB:  begin deg_base = DEG_W'(180); falling = 1'b1; end
      SEC_BM:  begin deg_base = DEG_W'(240); falling = 1'b0; end
      SEC_MR:  begin deg_base = DEG_W'(300); falling = 1'b1; end
      default: begin deg_base = DEG_W'(0);   falling = 1'b0; end
    endcase
    deg_off = deg2 - deg_base;
    tri_w   = falling ? (TRI_W'(DEG_SECTOR) - deg_off[TRI_W-1:0]) : deg_off[TRI_W-1:0];
  end

  // place chroma, x and zero on the channels
  always_comb begin
    case (sector4)
      SEC_RY:  begin base_r = cn4; base_g = xn4; base_b = '0;  end
      SEC_YG:  begin base_r = xn4; base_g = cn4; base_b = '0;  end
      SEC_GC:  begin base_r = '0;  base_g = cn4; base_b = xn4; end
      SEC_CB:  begin base_r = '0;  base_g = xn4; base_b = cn4; end
      SEC_BM:  begin base_r = xn4; base_g = '0;  base_b = cn4; end
      SEC_MR:  begin base_r = cn4; base_g = '0;  base_b = xn4; end
      default: begin base_r = '0;  base_g = '0;  base_b = '0;  end
    endcase
  end

  hsv2rgb_scale u_scale_r (.base(base_r), .offset(mn4), .level(lvl_r));
  hsv2rgb_scale u_scale_g (.base(base_g), .offset(mn4), .level(lvl_g));
  hsv2rgb_scale u_scale_b (.base(base_b), .offset(mn4), .level(lvl_b));

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start & ~busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  // payload stages, no reset
  always_ff @(posedge clk) begin
    // stage 1
    hue1    <= hsv.hue;
    quot1   <= hue_prod[HUE_SHIFT+QUOT_W-1:HUE_SHIFT];
    sat1    <= clamp_unit(hsv.saturation);
    val1    <= clamp_unit(hsv.brightness);
    // stage 2: chroma c = v * s, and v scaled to the same fraction
    deg2    <= deg_full[DEG_W-1:0];
    chroma2 <= PROD_W'(sat1) * PROD_W'(val1);
    vfull2  <= PROD_W'(val1) << FRAC_BITS;
    // stage 3: offset m = v - c
    sector3 <= sector;
    tri3    <= tri_w;
    chroma3 <= chroma2;
    offs3   <= vfull2 - chroma2;
    // stage 4: numerators
    sector4 <= sector3;
    xn4     <= NUM_W'(chroma3) * NUM_W'(tri3);
    cn4     <= NUM_W'(chroma3) * NUM_W'(DEG_SECTOR);
    mn4     <= NUM_W'(offs3) * NUM_W'(DEG_SECTOR);
    // stage 5: result
    rgb.red   <= lvl_r;
    rgb.green <= lvl_g;
    rgb.blue  <= lvl_b;
  end

endmodule

// File: design/hsv2rgb_checker.sv
// port-level checks on the hsv to rgb converter, bound to the top level
// depends on hsv2rgb_pkg and hsv_to_rgb_converter
module hsv2rgb_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input hsv2rgb_pkg::hsv_t hsv,
  input hsv2rgb_pkg::rgb_t rgb
);
  import hsv2rgb_pkg::*;

  // every taken item gives a result after the fixed latency
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("taken item gave no result");

  // no result without an item taken at the matching edge
  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without a taken item");

  // negative brightness clamps to black
  a_black: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && hsv.brightness[15]) |-> ##PIPE_DEPTH (done && rgb == '0))
    else $error("negative brightness not black");

  // negative saturation clamps to grey
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && hsv.saturation[15]) |->
      ##PIPE_DEPTH (rgb.red == rgb.green && rgb.green == rgb.blue))
    else $error("zero saturation not grey");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (.*);
